[hw/rtl/crcfr_pkg.sv]
// Shared types, codes and CRC helper for the CRC-16 frame receiver.
package crcfr_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] MAX_LEN_INIT = 16'hFFFF;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_ERR = 2'd1;
	localparam logic [1:0] ST_OVF     = 2'd2;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		OP_CRC_INIT,
		OP_CRC_FEED,
		OP_DATA,
		OP_CRC_HI,
		OP_END_CHK,
		OP_END_OVF
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [15:0] len;
	} entry_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hw/rtl/crc16_frame_receiver_top.sv]
// Top level of the length-prefixed CRC-16 frame receiver.
//
// Input channel: in_valid / in_stall carry rx_byte, one received byte per request.
// A frame is a 2-byte big-endian length, the payload, then a 2-byte CRC (high
// byte first), reflected CRC-16 poly 0x8408, init 0xFFFF, over length and payload.
// Output channel: out_valid / out_stall carry one result per request: a payload
// byte (kind 0) or the end-of-frame status (kind 1: ok, CRC error, overflow).
// Frames longer than max_length are swallowed; only the overflow status comes out.
// Config: cfg_valid / cfg_ready write max_length; write only while idle.
// Throughput: one byte per cycle while the queue is not full (see Stall). A result
// passes through the request queue, into which the parser writes its request, and
// then the output register, which the CRC back end loads.
// Stall: out_stall holds the output register; the back end halts at the next result
// entry, the queue (QUEUE_DEPTH entries) fills and then in_stall rises.
// Reset: max_length returns to 65535, the parser waits for a length high byte,
// queue and output are empty. No clearing pass is needed.
module crc16_frame_receiver_top #(
	parameter int unsigned QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic [15:0] frame_length
);
	import crcfr_pkg::*;

	logic   in_take;
	logic   push;
	entry_t push_entry;
	logic   full;
	logic   pop;
	entry_t head;
	logic   empty;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign in_take   = in_valid && !full;

	crcfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (max_length),
		.in_take    (in_take),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	crcfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	crcfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.status       (status),
		.frame_length (frame_length)
	);

	a_status_kind_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_STATUS) |-> data_byte == 8'h00)
		else $error("status result carries nonzero data");

	a_data_kind_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DATA) |-> status == ST_OK)
		else $error("data result carries nonzero status");

	a_status_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_CRC_ERR || status == ST_OVF))
		else $error("illegal status code");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("back end popped an empty queue");

endmodule

[hw/rtl/crcfr_front.sv]
// Front end: frame parser; each byte but overflow payload becomes a back-end request.
module crcfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [15:0]           cfg_data,
	input  logic                  in_take,
	input  logic [7:0]            rx_byte,
	output logic                  push,
	output crcfr_pkg::entry_t     push_entry
);
	import crcfr_pkg::*;

	typedef enum logic [2:0] {
		PH_LEN_HI  = 3'd0,
		PH_LEN_LO  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC_HI  = 3'd3,
		PH_CRC_LO  = 3'd4
	} phase_t;

	phase_t      phase_q;
	logic [15:0] len_q;
	logic [15:0] left_q;
	logic        ovf_q;
	logic [15:0] max_len_q;

	logic [15:0] len_lo;
	logic [15:0] left_dec;

	assign len_lo   = {len_q[15:8], rx_byte};
	assign left_dec = left_q - 16'd1;

	always_comb begin
		push_entry.data = rx_byte;
		push_entry.len  = len_q;
		push_entry.op   = OP_CRC_INIT;
		push            = in_take;
		unique case (phase_q)
			PH_LEN_LO: begin
				push_entry.op  = OP_CRC_FEED;
				push_entry.len = len_lo;
			end
			PH_PAYLOAD: begin
				push_entry.op = OP_DATA;
				push          = in_take && !ovf_q;
			end
			PH_CRC_HI: begin
				push_entry.op = OP_CRC_HI;
			end
			PH_CRC_LO: begin
				push_entry.op = ovf_q ? OP_END_OVF : OP_END_CHK;
			end
			default: begin
				push_entry.op  = OP_CRC_INIT;
				push_entry.len = {rx_byte, 8'h00};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN_HI;
			len_q     <= '0;
			left_q    <= '0;
			ovf_q     <= 1'b0;
			max_len_q <= MAX_LEN_INIT;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (in_take) begin
				unique case (phase_q)
					PH_LEN_LO: begin
						len_q   <= len_lo;
						left_q  <= len_lo;
						ovf_q   <= (len_lo > max_len_q);
						phase_q <= (len_lo != 16'd0) ? PH_PAYLOAD : PH_CRC_HI;
					end
					PH_PAYLOAD: begin
						left_q <= left_dec;
						if (left_dec == 16'd0) begin
							phase_q <= PH_CRC_HI;
						end
					end
					PH_CRC_HI: begin
						phase_q <= PH_CRC_LO;
					end
					PH_CRC_LO: begin
						phase_q <= PH_LEN_HI;
						left_q  <= '0;
						ovf_q   <= 1'b0;
					end
					default: begin
						len_q   <= {rx_byte, 8'h00};
						left_q  <= '0;
						ovf_q   <= 1'b0;
						phase_q <= PH_LEN_LO;
					end
				endcase
			end
		end
	end

endmodule

[hw/rtl/crcfr_queue.sv]
// Small register FIFO between parser and CRC back end.
module crcfr_queue #(
	parameter int unsigned DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crcfr_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output crcfr_pkg::entry_t head,
	output logic              empty
);
	import crcfr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/crcfr_back.sv]
// Back end: running CRC, check and output register for data and status results.
module crcfr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  crcfr_pkg::entry_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        data_byte,
	output logic [1:0]        status,
	output logic [15:0]       frame_length
);
	import crcfr_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  data_q;
	logic [1:0]  status_q;
	logic [15:0] len_q;

	logic        emits;
	logic        out_free;
	logic [15:0] crc_next;

	assign crc_next = crc_feed(crc_q, head.data);
	assign emits    = (head.op == OP_DATA) || (head.op == OP_END_CHK) ||
	                  (head.op == OP_END_OVF);
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !empty && (!emits || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			crc_hi_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= pop && emits;
			end
			if (pop) begin
				unique case (head.op)
					OP_CRC_INIT: crc_q    <= crc_feed(CRC_INIT, head.data);
					OP_CRC_FEED: crc_q    <= crc_next;
					OP_DATA:     crc_q    <= crc_next;
					OP_CRC_HI:   crc_hi_q <= head.data;
					OP_END_CHK: begin
						crc_q    <= CRC_INIT;
						crc_hi_q <= '0;
					end
					OP_END_OVF: begin
						crc_q    <= CRC_INIT;
						crc_hi_q <= '0;
					end
					default: crc_q <= crc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			len_q <= head.len;
			if (head.op == OP_DATA) begin
				kind_q   <= KIND_DATA;
				data_q   <= head.data;
				status_q <= ST_OK;
			end else begin
				kind_q <= KIND_STATUS;
				data_q <= '0;
				if (head.op == OP_END_OVF) begin
					status_q <= ST_OVF;
				end else if ({crc_hi_q, head.data} != crc_q) begin
					status_q <= ST_CRC_ERR;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign status       = status_q;
	assign frame_length = len_q;

endmodule
